>>> sv/pfc_fp_pkg.sv
package pfc_fp_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned RUN_W      = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned M_TDATA_W  = 24;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_COUNT_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERVOLTAGE_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERVOLTAGE_COUNT_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_VOLTAGE_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERVOLTAGE_LIMIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERVOLTAGE_COUNT_MAX  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_VALUE            = 3'd7;

    typedef struct packed {
        logic [14:0]                 current_limit;
        logic [RUN_W-1:0]            current_count_max;
        logic signed [SAMPLE_W-1:0]  undervoltage_limit;
        logic [RUN_W-1:0]            undervoltage_count_max;
        logic signed [SAMPLE_W-1:0]  clamp_voltage_limit;
        logic signed [SAMPLE_W-1:0]  overvoltage_limit;
        logic [RUN_W-1:0]            overvoltage_count_max;
        logic signed [SAMPLE_W-1:0]  clamp_value;
    } t_cfg;

    typedef struct packed {
        logic                        grid_locked;
        logic                        hard_overcurrent_pin;
        logic signed [SAMPLE_W-1:0]  grid_voltage_d;
        logic signed [SAMPLE_W-1:0]  output_voltage;
        logic signed [SAMPLE_W-1:0]  input_current;
    } t_sample;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  loop_override_value;
        logic                        loop_override;
        logic                        overvoltage_fault;
        logic                        undervoltage_fault;
        logic                        overcurrent_fault;
        logic                        shutdown;
    } t_result;

    // saturating persistence counter, cleared when the condition drops
    function automatic logic [RUN_W-1:0] f_run_next(input logic [RUN_W-1:0] run,
                                                    input logic cond);
        logic [RUN_W-1:0] v;
        if (!cond) begin
            v = '0;
        end else if (run == RUN_MAX) begin
            v = RUN_MAX;
        end else begin
            v = run + 1'b1;
        end
        return v;
    endfunction

endpackage

>>> sv/pfc_fp_cfg.sv
module pfc_fp_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pfc_fp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pfc_fp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pfc_fp_pkg::t_cfg                     o_cfg
);

    pfc_fp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_limit          <= 15'h7FFF;
            r_cfg.current_count_max      <= 8'd10;
            r_cfg.undervoltage_limit     <= 16'sd0;
            r_cfg.undervoltage_count_max <= 8'd10;
            r_cfg.clamp_voltage_limit    <= 16'sh7FFF;
            r_cfg.overvoltage_limit      <= 16'sh7FFF;
            r_cfg.overvoltage_count_max  <= 8'd10;
            r_cfg.clamp_value            <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pfc_fp_pkg::CFG_CURRENT_LIMIT: begin
                    r_cfg.current_limit <= i_cfg_data[14:0];
                end
                pfc_fp_pkg::CFG_CURRENT_COUNT_MAX: begin
                    r_cfg.current_count_max <= i_cfg_data[7:0];
                end
                pfc_fp_pkg::CFG_UNDERVOLTAGE_LIMIT: begin
                    r_cfg.undervoltage_limit <= i_cfg_data;
                end
                pfc_fp_pkg::CFG_UNDERVOLTAGE_COUNT_MAX: begin
                    r_cfg.undervoltage_count_max <= i_cfg_data[7:0];
                end
                pfc_fp_pkg::CFG_CLAMP_VOLTAGE_LIMIT: begin
                    r_cfg.clamp_voltage_limit <= i_cfg_data;
                end
                pfc_fp_pkg::CFG_OVERVOLTAGE_LIMIT: begin
                    r_cfg.overvoltage_limit <= i_cfg_data;
                end
                pfc_fp_pkg::CFG_OVERVOLTAGE_COUNT_MAX: begin
                    r_cfg.overvoltage_count_max <= i_cfg_data[7:0];
                end
                pfc_fp_pkg::CFG_CLAMP_VALUE: begin
                    r_cfg.clamp_value <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/pfc_fp_core.sv
module pfc_fp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  pfc_fp_pkg::t_cfg     i_cfg,
    input  pfc_fp_pkg::t_sample  i_sample,
    output pfc_fp_pkg::t_result  o_result
);

    logic [pfc_fp_pkg::RUN_W-1:0] r_current_run, n_current_run;
    logic [pfc_fp_pkg::RUN_W-1:0] r_uv_run, n_uv_run;
    logic [pfc_fp_pkg::RUN_W-1:0] r_ov_run, n_ov_run;
    logic r_current_flag, n_current_flag;
    logic r_uv_flag, n_uv_flag;
    logic r_ov_flag, n_ov_flag;

    logic signed [pfc_fp_pkg::SAMPLE_W:0] w_ia;
    logic signed [pfc_fp_pkg::SAMPLE_W:0] w_lim;
    logic w_oc_cond, w_uv_cond, w_ov_cond, w_override;
    logic w_oc_trip, w_uv_trip, w_ov_trip;

    always_comb begin
        w_ia  = {i_sample.input_current[pfc_fp_pkg::SAMPLE_W-1], i_sample.input_current};
        w_lim = $signed({2'b00, i_cfg.current_limit});
        w_oc_cond = (w_ia > w_lim) || (w_ia < -w_lim);
        w_uv_cond = i_sample.grid_locked &&
                    (i_sample.grid_voltage_d < i_cfg.undervoltage_limit);
        w_ov_cond  = i_sample.output_voltage > i_cfg.overvoltage_limit;
        w_override = i_sample.output_voltage > i_cfg.clamp_voltage_limit;

        n_current_run = pfc_fp_pkg::f_run_next(r_current_run, w_oc_cond);
        n_uv_run      = pfc_fp_pkg::f_run_next(r_uv_run, w_uv_cond);
        n_ov_run      = pfc_fp_pkg::f_run_next(r_ov_run, w_ov_cond);

        w_oc_trip = (n_current_run >= i_cfg.current_count_max) ||
                    i_sample.hard_overcurrent_pin;
        w_uv_trip = n_uv_run >= i_cfg.undervoltage_count_max;
        // stage two only trips on ticks where its condition holds
        w_ov_trip = w_ov_cond && (n_ov_run >= i_cfg.overvoltage_count_max);

        n_current_flag = r_current_flag | w_oc_trip;
        n_uv_flag      = r_uv_flag | w_uv_trip;
        n_ov_flag      = r_ov_flag | w_ov_trip;

        o_result.shutdown            = w_oc_trip | w_uv_trip | w_ov_trip;
        o_result.overcurrent_fault   = n_current_flag;
        o_result.undervoltage_fault  = n_uv_flag;
        o_result.overvoltage_fault   = n_ov_flag;
        o_result.loop_override       = w_override;
        o_result.loop_override_value = w_override ? i_cfg.clamp_value : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_run  <= '0;
            r_uv_run       <= '0;
            r_ov_run       <= '0;
            r_current_flag <= 1'b0;
            r_uv_flag      <= 1'b0;
            r_ov_flag      <= 1'b0;
        end else if (i_advance) begin
            r_current_run  <= n_current_run;
            r_uv_run       <= n_uv_run;
            r_ov_run       <= n_ov_run;
            r_current_flag <= n_current_flag;
            r_uv_flag      <= n_uv_flag;
            r_ov_flag      <= n_ov_flag;
        end
    end

endmodule

>>> sv/pfc_fault_protection.sv
// pfc fault protection: one beat in per control tick, one result beat out.
// input stream (i_s_*): samples of current, output voltage, grid d-axis voltage
// plus the hard over-current pin and the pll lock bit, packed into tdata.
// output stream (o_m_*): shutdown, three sticky fault flags, the loop override
// request and the clamp value to force, packed into tdata.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// at the clock edge; the user must write it only while no beat is in flight;
// the block itself does not enforce this. an accepted beat passes the input
// register, then the detectors, then the result register that drives o_m_tdata.
// throughput: one beat per cycle while i_m_tready is high; input and result
// registers each hold one beat, so a new sample is taken while a result waits
// to be taken. receiver stall: with i_m_tready low the result holds, the input
// register fills and then o_s_tready drops until the result is taken.
// reset (i_rst_n low, synchronous): both registers empty, run counters and
// fault flags cleared, configuration back to its defaults.
// fault flags clear only on reset; shutdown is high on every tick a trip fires.
module pfc_fault_protection (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [15:0] input_current, [31:16] output_voltage, [47:32] grid_voltage_d,
    // [48] hard_overcurrent_pin, [49] grid_locked, [55:50] zero
    input  logic [pfc_fp_pkg::S_TDATA_W-1:0]     i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [0] shutdown, [1] overcurrent_fault, [2] undervoltage_fault,
    // [3] overvoltage_fault, [4] loop_override, [20:5] loop_override_value,
    // [23:21] zero
    output logic [pfc_fp_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input  logic                                 i_cfg_we,
    input  logic [pfc_fp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pfc_fp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pfc_fp_pkg::t_cfg    w_cfg;
    pfc_fp_pkg::t_result w_result;
    pfc_fp_pkg::t_sample r_in;
    pfc_fp_pkg::t_result r_out;
    logic r_in_valid;
    logic r_out_valid;
    logic w_advance;
    logic w_s_accept;

    pfc_fp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pfc_fp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_cfg     (w_cfg),
        .i_sample  (r_in),
        .o_result  (w_result)
    );

    // a beat moves to the result register when that register is free or drains
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in <= i_s_tdata[49:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
            r_out       <= w_result;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out};

`ifndef SYNTH
    a_shutdown_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.shutdown |->
        (r_out.overcurrent_fault || r_out.undervoltage_fault || r_out.overvoltage_fault))
        else $error("shutdown without a fault flag");

    a_override_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.loop_override |-> r_out.loop_override_value == '0)
        else $error("override value nonzero without override");

    a_oc_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_out.overcurrent_fault))
        else $error("over-current flag cleared outside reset");

    a_ov_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_out.overvoltage_fault))
        else $error("over-voltage flag cleared outside reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && r_out_valid && !i_m_tready)
        else $error("input stalled with room in the pipeline");
`endif

endmodule
